[design/swm_pkg.sv]
// Shared constants, command/status bundles for the sliding window maximum block.
// Used by swm_ctrl, swm_dpath and the sliding_window_maximum top level.
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int PTR_W        = $clog2(MAX_WINDOW);      // deque slot index
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);  // deque fill, window, seen
    localparam int POS_W        = $clog2(2 * MAX_WINDOW);  // stream position mod 2*MAX_WINDOW
    localparam int WIN_W        = 7;                       // window_length register
    localparam int ENTRY_W      = SAMPLE_WIDTH + POS_W;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // capture the input transfer
        logic rd_front;    // read entry at head
        logic drop_head;   // drop head entry
        logic keep_front;  // latch head value as current maximum
        logic rd_back;     // read entry at tail
        logic drop_tail;   // drop tail entry
        logic push;        // append sample, load output slot if a result is due
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic count_zero;  // deque empty
        logic front_old;   // read entry has aged out of the window
        logic back_le;     // read entry not greater than the new sample
        logic out_free;    // output slot can take a result this cycle
    } t_status;

endpackage

`default_nettype wire

[design/sliding_window_maximum.sv]
// Top level of the sliding window maximum block: stream ports, controller and datapath.
// Depends on swm_pkg, swm_ctrl, swm_dpath (and swm_ram through the datapath).
`default_nettype none

// Sliding window maximum over a stream of signed 16-bit samples. The block keeps
// a monotonic deque of candidate maxima with their stream positions in a 64-entry
// RAM used as a ring buffer. Per sample the sequencer ages out front entries,
// prunes back entries that are not greater than the new sample (ties keep the
// newest), appends it, and once window_length samples of the sequence have been
// seen, emits the front value. tlast on the input ends a sequence: its result
// (if any) carries tlast, and the deque, position and sample count clear after
// it. A sequence shorter than the window gives no results. Window length is set
// through i_cfg_wr_en/i_cfg_wr_data (reset 3; 0 acts as 1, above 64 acts as 64)
// and should only be written while the block is idle. One sample at a time is
// processed: every deque entry examined (front entries that expire plus the
// first one kept, back entries pruned plus the first one kept) takes one read
// of the single RAM read port followed by a compare on the registered data,
// and a deque found empty goes straight to the append. A finished result sits
// in an output register, so the next sample is accepted while it waits on
// m_axis_tready; that sample's append stalls only if it has a result of its
// own and the register is still full.
module sliding_window_maximum (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [swm_pkg::WIN_W-1:0]        i_cfg_wr_data,   // window_length
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,    // [15:0] sample
    input  wire logic                             s_axis_tlast,    // last_sample
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [swm_pkg::SAMPLE_WIDTH-1:0]      m_axis_tdata,    // [15:0] window_max
    output logic                                  m_axis_tlast     // sequence_end
);
    import swm_pkg::*;

    t_cmd    cmd;
    t_status status;

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_max     (m_axis_tdata),
        .o_out_end     (m_axis_tlast)
    );

endmodule

`default_nettype wire

[design/swm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/swm_ctrl.sv]
// Sequencer for the sliding window maximum: steps front aging, back pruning and append.
// Depends on swm_pkg for the command and status bundles.
`default_nettype none

module swm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire swm_pkg::t_status i_status,
    output swm_pkg::t_cmd         o_cmd
);
    import swm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_RD_FRONT  = 6'b000010,
        S_CHK_FRONT = 6'b000100,
        S_RD_BACK   = 6'b001000,
        S_CHK_BACK  = 6'b010000,
        S_PUSH      = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_FRONT;
                end
            end
            S_RD_FRONT: begin
                if (i_status.count_zero) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_front = 1'b1;
                    n_state        = S_CHK_FRONT;
                end
            end
            S_CHK_FRONT: begin
                if (i_status.front_old) begin
                    o_cmd.drop_head = 1'b1;
                    n_state         = S_RD_FRONT;
                end else begin
                    o_cmd.keep_front = 1'b1;
                    n_state          = S_RD_BACK;
                end
            end
            S_RD_BACK: begin
                if (i_status.count_zero) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_back = 1'b1;
                    n_state       = S_CHK_BACK;
                end
            end
            S_CHK_BACK: begin
                if (i_status.back_le) begin
                    o_cmd.drop_tail = 1'b1;
                    n_state         = S_RD_BACK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/swm_dpath.sv]
// Datapath: deque storage (circular buffer in RAM), pointers, counters, output slot.
// Depends on swm_pkg and swm_ram.
`default_nettype none

module swm_dpath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [swm_pkg::WIN_W-1:0]        i_cfg_wr_data,
    input  wire logic [swm_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                             i_last,
    input  wire swm_pkg::t_cmd                    i_cmd,
    output swm_pkg::t_status                      o_status,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [swm_pkg::SAMPLE_WIDTH-1:0]      o_out_max,
    output logic                                  o_out_end
);
    import swm_pkg::*;

    logic [WIN_W-1:0]        r_win;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_last;
    logic [PTR_W-1:0]        r_head;
    logic [CNT_W-1:0]        r_count;
    logic [POS_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_seen;
    logic [SAMPLE_WIDTH-1:0] r_front_val;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_max;
    logic                    r_out_end;

    logic [CNT_W-1:0]        win_eff;
    logic [CNT_W-1:0]        n_seen;
    logic                    produce;
    logic [PTR_W-1:0]        tail_addr;
    logic [PTR_W-1:0]        wr_addr;
    logic [PTR_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]      rd_data;
    logic [SAMPLE_WIDTH-1:0] rd_val;
    logic [POS_W-1:0]        rd_pos;
    logic [POS_W-1:0]        age;

    // Register value 0 acts as 1, anything above the deque depth as the depth
    always_comb begin
        if (r_win == '0) begin
            win_eff = CNT_W'(1);
        end else if (CNT_W'(r_win) > CNT_W'(MAX_WINDOW)) begin
            win_eff = CNT_W'(MAX_WINDOW);
        end else begin
            win_eff = CNT_W'(r_win);
        end
    end

    assign n_seen  = (r_seen < CNT_W'(MAX_WINDOW)) ? r_seen + CNT_W'(1) : r_seen;
    assign produce = (n_seen >= win_eff);

    assign tail_addr = r_head + r_count[PTR_W-1:0] - PTR_W'(1);
    assign wr_addr   = r_head + r_count[PTR_W-1:0];
    assign rd_addr   = i_cmd.rd_front ? r_head : tail_addr;

    swm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_pos, r_sample}),
        .i_rd_en   (i_cmd.rd_front | i_cmd.rd_back),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_val = rd_data[SAMPLE_WIDTH-1:0];
    assign rd_pos = rd_data[ENTRY_W-1:SAMPLE_WIDTH];
    assign age    = r_pos - rd_pos;  // wraps mod 2*MAX_WINDOW

    assign o_status.count_zero = (r_count == '0);
    assign o_status.front_old  = (CNT_W'(age) >= win_eff);
    assign o_status.back_le    = ($signed(rd_val) <= $signed(r_sample));
    assign o_status.out_free   = !r_out_valid || i_out_ready || !produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_win <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (i_cmd.keep_front) begin
            r_front_val <= rd_val;
        end
        if (i_cmd.push && produce) begin
            r_out_max <= (r_count == '0) ? r_sample : r_front_val;
            r_out_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.drop_head) begin
                r_head  <= r_head + PTR_W'(1);
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.drop_tail) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.push) begin
                if (r_last) begin
                    r_count <= '0;
                    r_pos   <= '0;
                    r_seen  <= '0;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    r_pos   <= r_pos + POS_W'(1);
                    r_seen  <= n_seen;
                end
            end

            if (i_cmd.push && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_max   = r_out_max;
    assign o_out_end   = r_out_end;

endmodule

`default_nettype wire
